// ===== rtl/utf8_text_sanitizer_macros.svh =====
// Assertion macros shared by the sanitizer RTL.
`ifndef UTF8_TEXT_SANITIZER_MACROS_SVH
`define UTF8_TEXT_SANITIZER_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define UTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that expr is never true outside reset.
`define UTS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define UTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/utf8ts_pkg.sv =====
// Types and constants shared by the UTF-8 text sanitizer modules.
package utf8ts_pkg;

  localparam int unsigned SeqDepth  = 6;
  localparam int unsigned MaxRes    = 8;
  localparam int unsigned LenW      = 10;
  localparam int unsigned CntW      = 3;
  localparam int unsigned ResCntW   = 4;
  localparam int unsigned ResIdxW   = 3;

  localparam logic [LenW-1:0] MaxLengthReset = 10'd256;

  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQmark = 8'h3f;
  localparam logic [7:0] ChDel   = 8'h7f;
  localparam logic [7:0] ChNul   = 8'h00;

  // Per-string control state
  typedef struct packed {
    logic [CntW-1:0] needed;
    logic [CntW-1:0] held;
    logic            space_pending;
    logic            seen_nonspace;
    logic            stopped;
    logic [LenW-1:0] count;
  } ctl_t;

  // Results of one input byte, handed to the output buffer
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [ResCntW-1:0]     cnt;
    logic                   has_bytes;
    logic                   eos;
  } res_t;

endpackage

// ===== rtl/utf8ts_step.sv =====
// Combinational processing of one source byte: escape, validate, collapse spaces.
module utf8ts_step (
  input  utf8ts_pkg::ctl_t                               ctl_i,
  input  logic [utf8ts_pkg::SeqDepth-1:0][7:0]           seq_i,
  input  logic [7:0]                                     in_byte_i,
  input  logic                                           last_i,
  input  logic [utf8ts_pkg::LenW-1:0]                    max_length_i,
  output utf8ts_pkg::ctl_t                               ctl_d_o,
  output logic [utf8ts_pkg::SeqDepth-1:0][7:0]           seq_d_o,
  output utf8ts_pkg::res_t                               res_o
);
  import utf8ts_pkg::*;

  typedef struct packed {
    ctl_t                     c;
    logic [SeqDepth-1:0][7:0] seq;
    logic [MaxRes-1:0][7:0]   res;
    logic [ResCntW-1:0]       n;
  } work_t;

  // Append one byte to the result list
  function automatic work_t push_b(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    r.res[r.n[ResIdxW-1:0]] = b;
    r.n = r.n + ResCntW'(1);
    return r;
  endfunction

  // Emit a collapsed space if one waits
  function automatic work_t flush_space(work_t w);
    work_t r;
    r = w;
    if (r.c.space_pending) begin
      r = push_b(r, ChSpace);
      r.c.space_pending = 1'b0;
    end
    return r;
  endfunction

  // Emit '?' and drop the rest of the string
  function automatic work_t fail(work_t w);
    work_t r;
    r = flush_space(w);
    r = push_b(r, ChQmark);
    r.c.stopped = 1'b1;
    r.c.needed  = '0;
    r.c.held    = '0;
    return r;
  endfunction

  // Consume one escaped byte
  function automatic work_t take(work_t w, logic [7:0] b, logic [LenW-1:0] maxlen);
    work_t           r;
    logic [CntW-1:0] nb;
    logic            bad_lead;
    r        = w;
    nb       = '0;
    bad_lead = 1'b0;
    if (!(r.c.stopped || r.c.count >= maxlen)) begin
      r.c.count = r.c.count + LenW'(1);
      if (r.c.needed != '0) begin
        if (b[7:6] != 2'b10) begin
          r = fail(r);
        end else begin
          if (r.c.held < CntW'(SeqDepth)) r.seq[r.c.held] = b;
          r.c.held   = r.c.held + CntW'(1);
          r.c.needed = r.c.needed - CntW'(1);
          if (r.c.needed == '0) begin
            r = flush_space(r);
            for (int i = 0; i < SeqDepth; i++) begin
              if (CntW'(i) < r.c.held) r = push_b(r, r.seq[i]);
            end
            r.c.held          = '0;
            r.c.seen_nonspace = 1'b1;
          end else if (r.c.count >= maxlen) begin
            r = fail(r);
          end
        end
      end else if (!b[7]) begin
        if (b < ChSpace || b == ChDel) begin
          r = fail(r);
        end else if (b == ChSpace) begin
          if (r.c.seen_nonspace) r.c.space_pending = 1'b1;
        end else begin
          r = flush_space(r);
          r = push_b(r, b);
          r.c.seen_nonspace = 1'b1;
        end
      end else begin
        // Decode the lead byte into its continuation count
        if      (b[7:6] == 2'b10)      bad_lead = 1'b1;
        else if (b[7:5] == 3'b110)     nb = CntW'(1);
        else if (b[7:4] == 4'b1110)    nb = CntW'(2);
        else if (b[7:3] == 5'b11110)   nb = CntW'(3);
        else if (b[7:2] == 6'b111110)  nb = CntW'(4);
        else if (b[7:1] == 7'b1111110) nb = CntW'(5);
        else                           bad_lead = 1'b1;
        if (bad_lead) begin
          r = fail(r);
        end else begin
          r.seq[0]   = b;
          r.c.held   = CntW'(1);
          r.c.needed = nb;
          if (r.c.count >= maxlen) r = fail(r);
        end
      end
    end
    return r;
  endfunction

  work_t w0, w1, w2, w3;
  logic  ends;

  // Run the byte, doubled when it is a quote, then close the string if needed
  always_comb begin
    ends      = (in_byte_i == ChNul) || last_i;
    w0.c      = ctl_i;
    w0.seq    = seq_i;
    w0.res    = '0;
    w0.n      = '0;
    w1        = (in_byte_i != ChNul) ? take(w0, in_byte_i, max_length_i) : w0;
    w2        = (in_byte_i == ChQuote) ? take(w1, in_byte_i, max_length_i) : w1;
    w3        = (ends && !w2.c.stopped && w2.c.needed != '0) ? fail(w2) : w2;
  end

  // Build the result bundle and next state
  always_comb begin
    res_o.bytes     = w3.res;
    res_o.has_bytes = (w3.n != '0);
    res_o.cnt       = (w3.n != '0) ? w3.n : ResCntW'(1);
    res_o.eos       = ends;
    seq_d_o         = w3.seq;
    ctl_d_o         = ends ? '0 : w3.c;
  end

endmodule

// ===== rtl/utf8ts_obuf.sv =====
// Result buffer: holds one byte's results and sends one per cycle while ready.
module utf8ts_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  utf8ts_pkg::res_t  res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              end_of_run_o,
  output logic              end_of_string_o
);
  import utf8ts_pkg::*;

  logic               valid_q;
  logic [ResIdxW-1:0] idx_q;
  res_t               res_q;
  logic               last_entry;
  logic               fire;

  assign last_entry  = ({1'b0, idx_q} + ResCntW'(1)) == res_q.cnt;
  assign fire        = valid_q && out_ready_i;
  assign can_load_o  = !valid_q || (fire && last_entry);

  assign out_valid_o     = valid_q;
  assign out_byte_o      = res_q.has_bytes ? res_q.bytes[idx_q] : ChNul;
  assign byte_valid_o    = res_q.has_bytes;
  assign end_of_run_o    = last_entry;
  assign end_of_string_o = last_entry && res_q.eos;

  // Advance through the entries, reload when the last one goes out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire && last_entry) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + ResIdxW'(1);
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/utf8_text_sanitizer.sv =====
// UTF-8 text sanitizer top level: input register, step logic, result buffer.
//
// Source bytes arrive on the in_* channel (in_byte_i, last_i) under
// valid/ready. A zero byte or last_i ends the string; each single quote is
// doubled, UTF-8 is checked, spaces are trimmed and collapsed, and the first
// bad byte yields '?' and drops the rest of the string.
// Each request produces 1 to 7 results on the out_* channel: out_byte_o with
// byte_valid_o (0 marks an empty marker), end_of_run_o on the last result of
// the request and end_of_string_o on the last result of the string.
// An accepted request waits in the input register until the result buffer
// can load it; the step logic's results are registered there and offered.
// The result buffer sends one result per cycle while out_ready_i is high,
// so one-result requests pass at one request per cycle.
// The buffer loads the next request's results as its last entry leaves.
// When the receiver stalls, the buffer holds and the input register takes
// one more request, then in_ready_o drops.
// max_length is written on the cfg_* channel (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
// Reset clears all string state and sets max_length to 256.
`include "utf8_text_sanitizer_macros.svh"

module utf8_text_sanitizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          byte_valid_o,
  output logic                          end_of_run_o,
  output logic                          end_of_string_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utf8ts_pkg::LenW-1:0]   cfg_max_length_i
);
  import utf8ts_pkg::*;

  logic                     in_valid_q;
  logic [7:0]               byte_q;
  logic                     last_q;
  logic [LenW-1:0]          max_length_q;
  ctl_t                     ctl_q, ctl_d;
  logic [SeqDepth-1:0][7:0] seq_q, seq_d;
  res_t                     res;
  logic                     can_load;
  logic                     proc;

  assign proc        = in_valid_q && can_load;
  assign in_ready_o  = !in_valid_q || can_load;
  assign cfg_ready_o = 1'b1;

  // Hold the register value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthReset;
    end else if (cfg_valid_i) begin
      max_length_q <= cfg_max_length_i;
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      last_q <= last_i;
    end
  end

  // Advance the string state when a request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (proc) begin
      ctl_q <= ctl_d;
    end
  end

  // Sequence bytes need no reset: always written before read
  always_ff @(posedge clk_i) begin
    if (proc) begin
      seq_q <= seq_d;
    end
  end

  utf8ts_step u_step (
    .ctl_i        (ctl_q),
    .seq_i        (seq_q),
    .in_byte_i    (byte_q),
    .last_i       (last_q),
    .max_length_i (max_length_q),
    .ctl_d_o      (ctl_d),
    .seq_d_o      (seq_d),
    .res_o        (res)
  );

  utf8ts_obuf u_obuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (proc),
    .res_i           (res),
    .can_load_o      (can_load),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_run_o    (end_of_run_o),
    .end_of_string_o (end_of_string_o)
  );

  // A stopped string never keeps an open sequence
  `UTS_ASSERT_NEVER(a_stop_no_seq, clk_i, rst_ni,
                    ctl_q.stopped && ctl_q.needed != '0, "stopped with open sequence")
  // Held plus missing bytes fit the sequence buffer
  `UTS_ASSERT(a_seq_fits, clk_i, rst_ni,
              ({1'b0, ctl_q.held} + {1'b0, ctl_q.needed}) <= 4'(SeqDepth), "sequence overflow")
  // A waiting request is not overwritten while the buffer is busy
  `UTS_ASSERT(a_in_hold, clk_i, rst_ni,
              (in_valid_q && !can_load) |=> (in_valid_q && $stable(byte_q) && $stable(last_q)),
              "input register lost a request")
  // End of string only on the final result of a request
  `UTS_ASSERT(a_eos_run, clk_i, rst_ni,
              (out_valid_o && end_of_string_o) |-> end_of_run_o, "end of string without end of run")

endmodule
